### hdl/frame_deframer_xor_checksum_assert.svh
// Assertion macros shared by the deframer RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef FRAME_DEFRAMER_XOR_CHECKSUM_ASSERT_SVH
`define FRAME_DEFRAMER_XOR_CHECKSUM_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FDXC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication whose consequent is due in the next cycle.
`define FDXC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hdl/fdxc_pkg.sv
// Shared types and constants of the XOR-checksum frame deframer.
// No dependencies; imported by every other RTL file but the assertion header.
`default_nettype none

package fdxc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned ID_W     = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 1'b1;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] MAX_LEN_RST      = 8'hFF;

	localparam logic [POS_W-1:0] POS_START   = 9'd0;
	localparam logic [POS_W-1:0] POS_ID_HI   = 9'd1;
	localparam logic [POS_W-1:0] POS_ID_LO   = 9'd2;
	localparam logic [POS_W-1:0] POS_TYPE    = 9'd3;
	localparam logic [POS_W-1:0] POS_LEN     = 9'd4;
	localparam logic [POS_W-1:0] HEADER_BYTES = 9'd5;
	localparam logic [POS_W-1:0] POS_MAX     = 9'h1FF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_SHORT     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_START = 3'd2;
	localparam logic [STATUS_W-1:0] STS_BAD_SUM   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_OVER      = 3'd4;
	localparam logic [STATUS_W-1:0] STS_MISMATCH  = 3'd5;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              frame_end;
	} in_beat_t;

	typedef struct packed {
		logic                result_kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic [BYTE_W-1:0]   payload_index;
		logic [STATUS_W-1:0] frame_status;
		logic [ID_W-1:0]     message_id;
		logic [BYTE_W-1:0]   message_type;
		logic [BYTE_W-1:0]   payload_length;
	} out_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] max_payload_len;
	} cfg_t;

endpackage

`default_nettype wire

### hdl/fdxc_if.sv
// Valid/ready stream interfaces for received bytes and deframer results.
// Depends on fdxc_pkg for the beat types.
`default_nettype none

interface fdxc_in_if
	import fdxc_pkg::*;
();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fdxc_out_if
	import fdxc_pkg::*;
();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/frame_deframer_xor_checksum.sv
// Top level of the XOR-checksum frame deframer.
// Depends on fdxc_pkg, fdxc_if, fdxc_cfg_regs, fdxc_in_stage, fdxc_parser, fdxc_out_fifo.
//
// Channel  Dir  Handshake            Beat
// rx       in   valid/ready          rx_byte, frame_end
// result   out  valid/ready          kind, payload byte/index, status, header fields
// cfg      in   cfg_we (no stall)    cfg_idx, cfg_wdata
//
// One byte per cycle unless the result buffer is full; the parser updates position and XOR.
// A result passes the input register and the result buffer before it is valid on result.
// Reset clears frame state and restores start marker 0xAA and length limit 0xFF.
// A stalled result channel fills the two-entry result buffer, then holds the input register.
`default_nettype none

module frame_deframer_xor_checksum
	import fdxc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	fdxc_in_if.sink                   rx,
	fdxc_out_if.source                result
);

	cfg_t      cfg;
	logic      adv;
	in_beat_t  beat;
	logic      res_valid;
	out_beat_t res;
	logic      buf_ready;

	fdxc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fdxc_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.down_ready (buf_ready),
		.adv        (adv),
		.beat       (beat)
	);

	fdxc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.beat      (beat),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	fdxc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && res_valid),
		.push_data (res),
		.ready     (buf_ready),
		.result    (result)
	);

endmodule

`default_nettype wire

### hdl/fdxc_cfg_regs.sv
// Configuration registers: start marker and payload length limit.
// Depends on fdxc_pkg.
`default_nettype none

module fdxc_cfg_regs
	import fdxc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker    <= START_MARKER_RST;
			cfg_q.max_payload_len <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_START_MARKER: cfg_q.start_marker    <= cfg_wdata;
				CFG_MAX_LEN:      cfg_q.max_payload_len <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/fdxc_in_stage.sv
// Input register for received bytes; holds a beat while downstream is full.
// Depends on fdxc_pkg, fdxc_in_if and the assertion macros.
`default_nettype none
`include "frame_deframer_xor_checksum_assert.svh"

module fdxc_in_stage
	import fdxc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	fdxc_in_if.sink    rx,
	input  wire logic  down_ready,
	output logic       adv,
	output in_beat_t   beat
);

	logic     valid_s1;
	in_beat_t beat_s1;

	assign adv      = valid_s1 && down_ready;
	assign rx.ready = !valid_s1 || down_ready;
	assign beat     = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			beat_s1 <= rx.data;
		end
	end

	`FDXC_ASSERT_NEXT(a_hold_stalled, valid_s1 && !down_ready,
		valid_s1 && $stable(beat_s1), "stalled input beat lost")

endmodule

`default_nettype wire

### hdl/fdxc_parser.sv
// Frame parser: position, running XOR, header capture, payload and status results.
// Depends on fdxc_pkg and the assertion macros.
`default_nettype none
`include "frame_deframer_xor_checksum_assert.svh"

module fdxc_parser
	import fdxc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire in_beat_t beat,
	input  wire cfg_t     cfg,
	output logic          res_valid,
	output out_beat_t     res
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] xor_q;
	logic [ID_W-1:0]   id_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] len_q;
	logic              matched_q;

	logic [POS_W-1:0] len_ext;
	logic [POS_W-1:0] expected_pos;
	logic [POS_W-1:0] offset;
	logic             too_short;
	logic             len_ok;
	logic             in_payload;

	always_comb begin
		len_ext      = {1'b0, len_q};
		expected_pos = len_ext + HEADER_BYTES;
		offset       = pos_q - HEADER_BYTES;
		too_short    = pos_q < HEADER_BYTES;
		len_ok       = len_q <= cfg.max_payload_len;
		in_payload   = matched_q && !too_short && (offset < len_ext) && len_ok;

		res       = '0;
		res_valid = 1'b0;
		if (beat.frame_end) begin
			res_valid       = 1'b1;
			res.result_kind = KIND_STATUS;
			if (too_short)
				res.frame_status = STS_SHORT;
			else if (!matched_q)
				res.frame_status = STS_BAD_START;
			else if (xor_q != beat.rx_byte)
				res.frame_status = STS_BAD_SUM;
			else if (!len_ok)
				res.frame_status = STS_OVER;
			else if (pos_q != expected_pos)
				res.frame_status = STS_MISMATCH;
			else
				res.frame_status = STS_OK;
			if (!too_short && matched_q) begin
				res.message_id     = id_q;
				res.message_type   = type_q;
				res.payload_length = len_q;
			end
		end else if (in_payload) begin
			res_valid         = 1'b1;
			res.result_kind   = KIND_PAYLOAD;
			res.payload_byte  = beat.rx_byte;
			res.payload_index = offset[BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= '0;
			id_q      <= '0;
			type_q    <= '0;
			len_q     <= '0;
			matched_q <= 1'b0;
		end else if (adv) begin
			if (beat.frame_end) begin
				pos_q     <= '0;
				xor_q     <= '0;
				id_q      <= '0;
				type_q    <= '0;
				len_q     <= '0;
				matched_q <= 1'b0;
			end else begin
				unique case (pos_q)
					POS_START: matched_q         <= (beat.rx_byte == cfg.start_marker);
					POS_ID_HI: id_q[ID_W-1:BYTE_W] <= beat.rx_byte;
					POS_ID_LO: id_q[BYTE_W-1:0]    <= beat.rx_byte;
					POS_TYPE:  type_q            <= beat.rx_byte;
					POS_LEN:   len_q             <= beat.rx_byte;
					default: ;
				endcase
				xor_q <= xor_q ^ beat.rx_byte;
				if (pos_q != POS_MAX)
					pos_q <= pos_q + 9'd1;
			end
		end
	end

	`FDXC_ASSERT_NEXT(a_clear_on_end, adv && beat.frame_end,
		pos_q == '0 && !matched_q && xor_q == '0, "frame state not cleared")
	`FDXC_ASSERT(a_payload_matched,
		!(res_valid && !beat.frame_end) || (matched_q && pos_q >= HEADER_BYTES),
		"payload beat outside a matched frame")

endmodule

`default_nettype wire

### hdl/fdxc_out_fifo.sv
// Two-entry result buffer between the parser and the result channel.
// Depends on fdxc_pkg, fdxc_out_if and the assertion macros.
`default_nettype none
`include "frame_deframer_xor_checksum_assert.svh"

module fdxc_out_fifo
	import fdxc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire out_beat_t push_data,
	output logic           ready,
	fdxc_out_if.source     result
);

	out_beat_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign ready        = (count_q != 2'd2);
	assign result.valid = (count_q != 2'd0);
	assign result.data  = mem_q[rd_ptr_q];
	assign pop          = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`FDXC_ASSERT(a_no_overflow, !push || ready, "push into full result buffer")
	`FDXC_ASSERT_NEXT(a_fill, push && !pop && count_q == 2'd1, count_q == 2'd2,
		"result buffer count wrong")

endmodule

`default_nettype wire

### bench/frame_deframer_xor_checksum_test.sv
// Self-checking bench for the XOR-checksum frame deframer: a directed frame table, then random
// frames over several register settings, with random byte gaps and result stalls.
// Depends on fdxc_pkg, fdxc_if and frame_deframer_xor_checksum.

module frame_deframer_xor_checksum_test;
	import fdxc_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 70;
	localparam int NUM_PHASES   = 7;

	typedef enum {
		SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_BAD_START, SHAPE_SHORT, SHAPE_TRAILING,
		SHAPE_TRUNCATED, SHAPE_NOISE, SHAPE_LONG, SHAPE_FULL
	} frame_shape_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   rx_byte;
		logic                frame_end;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [BYTE_W-1:0]   msg_type;
		logic [BYTE_W-1:0]   len_field;
	} stim_row_t;

	typedef struct {
		logic      typed;
		out_beat_t want;
	} row_check_t;

	localparam stim_row_t DIRECTED_ROWS [0:26] = '{
		'{8'hAA, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h12, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h34, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h56, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hDA, 1'b1, 1'b1, STS_OK,        16'h1234, 8'h56, 8'h00},
		'{8'hFF, 1'b1, 1'b1, STS_SHORT,     16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b1, 1'b1, STS_BAD_START, 16'h0000, 8'h00, 8'h00},
		'{8'hAA, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h02, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b1, 1'b1, STS_BAD_SUM,   16'hFFFF, 8'hFF, 8'h02},
		'{8'hAA, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'h01, 1'b0, 1'b0, STS_OK,        16'h0000, 8'h00, 8'h00},
		'{8'hAB, 1'b1, 1'b1, STS_MISMATCH,  16'h0000, 8'h00, 8'h01}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [BYTE_W-1:0]    cfg_wdata;

	fdxc_in_if  rx ();
	fdxc_out_if result ();

	frame_deframer_xor_checksum DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.rx       (rx),
		.result   (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [POS_W-1:0]  frame_pos;
	logic [BYTE_W-1:0] frame_xor;
	logic [ID_W-1:0]   hdr_id;
	logic [BYTE_W-1:0] hdr_type;
	logic [BYTE_W-1:0] hdr_len;
	logic              start_ok;
	logic [BYTE_W-1:0] marker_mirror;
	logic [BYTE_W-1:0] limit_mirror;
	out_beat_t         awaited_beats[$];
	row_check_t        row_checks[$];

	logic [BYTE_W-1:0] cur_marker = START_MARKER_RST;
	logic              calm = 1'b0;
	int                stall_left = 0;
	int                quiet_cycles = 0;
	int                errors = 0;
	int                bytes_taken = 0;
	int                bytes_sent = 0;
	int                payload_seen = 0;
	int                status_seen [0:7] = '{default: 0};
	logic              made;
	out_beat_t         beat;
	row_check_t        row;
	int                phase;
	int                phase_start;

	task automatic clear_frame();
		frame_pos = '0;
		frame_xor = '0;
		hdr_id    = '0;
		hdr_type  = '0;
		hdr_len   = '0;
		start_ok  = 1'b0;
	endtask

	task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic last,
			output logic produced, output out_beat_t r);
		int p;
		p = int'(frame_pos);
		r = '0;
		produced = 1'b0;
		if (last) begin
			produced = 1'b1;
			r.result_kind = KIND_STATUS;
			if (p + 1 < int'(HEADER_BYTES) + 1)
				r.frame_status = STS_SHORT;
			else if (!start_ok)
				r.frame_status = STS_BAD_START;
			else if (frame_xor != b)
				r.frame_status = STS_BAD_SUM;
			else if (hdr_len > limit_mirror)
				r.frame_status = STS_OVER;
			else if (p + 1 != int'(hdr_len) + int'(HEADER_BYTES) + 1)
				r.frame_status = STS_MISMATCH;
			else
				r.frame_status = STS_OK;
			if (r.frame_status != STS_SHORT && r.frame_status != STS_BAD_START) begin
				r.message_id     = hdr_id;
				r.message_type   = hdr_type;
				r.payload_length = hdr_len;
			end
			clear_frame();
		end else begin
			case (frame_pos)
				POS_START: start_ok = (b == marker_mirror);
				POS_ID_HI: hdr_id[ID_W-1:BYTE_W] = b;
				POS_ID_LO: hdr_id[BYTE_W-1:0] = b;
				POS_TYPE:  hdr_type = b;
				POS_LEN:   hdr_len = b;
				default: ;
			endcase
			frame_xor = frame_xor ^ b;
			if (frame_pos != POS_MAX)
				frame_pos = frame_pos + POS_W'(1);
			if (start_ok && p >= int'(HEADER_BYTES) && p - int'(HEADER_BYTES) < int'(hdr_len)
					&& hdr_len <= limit_mirror) begin
				produced        = 1'b1;
				r.result_kind   = KIND_PAYLOAD;
				r.payload_byte  = b;
				r.payload_index = BYTE_W'(p - int'(HEADER_BYTES));
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	task automatic check_beat(input out_beat_t got);
		out_beat_t want;
		if (awaited_beats.size() == 0) begin
			report_mismatch("result with nothing awaited", 64'(got), 64'd0);
			return;
		end
		want = awaited_beats.pop_front();
		if (got.result_kind !== want.result_kind)
			report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
		if (got.payload_byte !== want.payload_byte)
			report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
		if (got.payload_index !== want.payload_index)
			report_mismatch("payload_index", 64'(got.payload_index),
				64'(want.payload_index));
		if (got.frame_status !== want.frame_status)
			report_mismatch("frame_status", 64'(got.frame_status), 64'(want.frame_status));
		if (got.message_id !== want.message_id)
			report_mismatch("message_id", 64'(got.message_id), 64'(want.message_id));
		if (got.message_type !== want.message_type)
			report_mismatch("message_type", 64'(got.message_type), 64'(want.message_type));
		if (got.payload_length !== want.payload_length)
			report_mismatch("payload_length", 64'(got.payload_length),
				64'(want.payload_length));
		if (want.result_kind == KIND_STATUS)
			status_seen[want.frame_status]++;
		else
			payload_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			marker_mirror = START_MARKER_RST;
			limit_mirror  = MAX_LEN_RST;
			quiet_cycles  = 0;
		end else begin
			if (rx.valid && rx.ready) begin
				deframe_byte(rx.data.rx_byte, rx.data.frame_end, made, beat);
				if (row_checks.size() > 0) begin
					row = row_checks.pop_front();
					if (row.typed) begin
						made = 1'b1;
						beat = row.want;
					end
				end
				if (made)
					awaited_beats.push_back(beat);
				bytes_taken++;
			end
			if (result.valid && result.ready)
				check_beat(result.data);
			if (cfg_we) begin
				case (cfg_idx)
					CFG_START_MARKER: marker_mirror = cfg_wdata;
					CFG_MAX_LEN:      limit_mirror = cfg_wdata;
					default: ;
				endcase
			end
			if ((rx.valid && rx.ready) || (result.valid && result.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_left = pick_gap();
			result.ready <= (stall_left == 0);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.data  <= in_beat_t'{rx_byte: b, frame_end: last};
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
	endtask

	task automatic hold_until_drained(input int settle);
		rx.valid <= 1'b0;
		@(posedge clk);
		wait (awaited_beats.size() == 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic load_setting(input logic [BYTE_W-1:0] marker,
			input logic [BYTE_W-1:0] limit);
		hold_until_drained(DRAIN_CYCLES);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_START_MARKER;
		cfg_wdata <= marker;
		@(posedge clk);
		cfg_idx   <= CFG_MAX_LEN;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_marker = marker;
	endtask

	function automatic frame_shape_t pick_shape();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return SHAPE_GOOD;
		if (r < 63) return SHAPE_BAD_SUM;
		if (r < 70) return SHAPE_BAD_START;
		if (r < 77) return SHAPE_SHORT;
		if (r < 85) return SHAPE_TRAILING;
		if (r < 92) return SHAPE_TRUNCATED;
		return SHAPE_NOISE;
	endfunction

	task automatic send_frame(input frame_shape_t shape);
		logic [BYTE_W-1:0] fb[$];
		logic [BYTE_W-1:0] sum;
		int                len;
		int                body;
		int                n;
		if ($urandom_range(0, 9) == 0)
			calm = !calm;
		case (shape) inside
			SHAPE_SHORT, SHAPE_NOISE: begin
				n = (shape == SHAPE_SHORT) ? $urandom_range(1, 5) : $urandom_range(6, 14);
				repeat (n) fb.push_back(BYTE_W'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					fb[0] = cur_marker;
			end
			default: begin
				if (shape == SHAPE_FULL)
					len = 255;
				else if (shape == SHAPE_LONG)
					len = $urandom_range(0, 255);
				else if ($urandom_range(0, 99) < 80)
					len = $urandom_range(0, 8);
				else
					len = $urandom_range(9, 40);
				body = len;
				if (shape == SHAPE_LONG)
					body = 510;
				if (shape == SHAPE_TRAILING)
					body = len + $urandom_range(1, 4);
				if (shape == SHAPE_TRUNCATED)
					body = (len == 0) ? 1 : $urandom_range(0, len - 1);
				if (shape == SHAPE_BAD_START)
					fb.push_back(cur_marker ^ BYTE_W'($urandom_range(1, 255)));
				else
					fb.push_back(cur_marker);
				repeat (3) fb.push_back(BYTE_W'($urandom_range(0, 255)));
				fb.push_back(BYTE_W'(len));
				repeat (body) fb.push_back(BYTE_W'($urandom_range(0, 255)));
				sum = '0;
				foreach (fb[i]) sum = sum ^ fb[i];
				if (shape == SHAPE_BAD_SUM)
					sum = sum ^ BYTE_W'($urandom_range(1, 255));
				fb.push_back(sum);
			end
		endcase
		foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
		bytes_sent += fb.size();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_START_MARKER;
		cfg_wdata    = '0;
		rx.valid     = 1'b0;
		rx.data      = '0;
		result.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			row.typed = DIRECTED_ROWS[i].typed;
			row.want  = out_beat_t'{KIND_STATUS, 8'h00, 8'h00, DIRECTED_ROWS[i].status,
				DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].msg_type, DIRECTED_ROWS[i].len_field};
			row_checks.push_back(row);
			send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].frame_end);
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				1: load_setting(8'h00, 8'h00);
				2: load_setting(8'hFF, 8'hFF);
				3: load_setting(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(1, 16)));
				4: load_setting(8'h55, 8'h07);
				5: load_setting(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
				6: load_setting(START_MARKER_RST, MAX_LEN_RST);
				default: ;
			endcase
			if (phase == 0)
				send_frame(SHAPE_FULL);
			if (phase == 2)
				send_frame(SHAPE_LONG);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				send_frame(pick_shape());
				if ($urandom_range(0, 19) == 0)
					hold_until_drained(0);
			end
		end

		hold_until_drained(DRAIN_CYCLES);
		$display("run covered %0d bytes over %0d register settings, %0d payload beats checked",
			bytes_taken, NUM_PHASES, payload_seen);
		$display("frame status: ok %0d short %0d bad start %0d bad sum %0d over %0d mismatch %0d",
			status_seen[STS_OK], status_seen[STS_SHORT], status_seen[STS_BAD_START],
			status_seen[STS_BAD_SUM], status_seen[STS_OVER], status_seen[STS_MISMATCH]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
